>>> src/tfl_pkg.sv
// shared types and constants of the tilt filter led level block
package tfl_pkg;

  localparam int TAPS_DEF   = 25;
  localparam int ANGLE_W    = 14;
  localparam int COEF_W     = 16;
  localparam int CIDX_W     = 5;
  localparam int GOAL_W     = 13;
  localparam int LEVEL_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = GOAL_W;

  // product of one sample and one coefficient
  localparam int PROD_W     = ANGLE_W + COEF_W;
  localparam int FRAC_W     = 15;
  localparam int FILT_MAX   = 32767;
  localparam int FILT_MIN   = -32768;
  // magnitude of the filtered value and the error against the goal
  localparam int ERR_W      = 17;

  // level = min(err / 360, 30); 360 = 8 * 45, the 45 by reciprocal
  localparam int LEVEL_DIV   = 360;
  localparam int LEVEL_MAX   = 30;
  localparam int LEVEL_CAP   = LEVEL_DIV * LEVEL_MAX;
  localparam int CAP_W       = 14;
  localparam int DIV_SHIFT   = 3;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + (LEVEL_DIV >> DIV_SHIFT) - 1)
                               / (LEVEL_DIV >> DIV_SHIFT);
  localparam int Y_W         = CAP_W - DIV_SHIFT;
  localparam int RPROD_W     = Y_W + 11;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_COEF   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROLL_GOAL  = 1'b0,
    REG_PITCH_GOAL = 1'b1
  } cfg_reg_t;

endpackage

>>> src/tfl_ifs.sv
// handshake channels of the tilt filter led level block
interface tfl_in_if;
  logic                                valid;
  logic                                ready;
  tfl_pkg::op_t                        op;
  logic signed [tfl_pkg::ANGLE_W-1:0]  roll_angle;
  logic signed [tfl_pkg::ANGLE_W-1:0]  pitch_angle;
  logic [tfl_pkg::CIDX_W-1:0]          coef_index;
  logic signed [tfl_pkg::COEF_W-1:0]   coef_value;

  modport source (output valid, op, roll_angle, pitch_angle, coef_index, coef_value,
                  input ready);
  modport sink (input valid, op, roll_angle, pitch_angle, coef_index, coef_value,
                output ready);
endinterface

interface tfl_out_if;
  logic                          valid;
  logic                          ready;
  logic [tfl_pkg::LEVEL_W-1:0]   roll_level;
  logic [tfl_pkg::LEVEL_W-1:0]   pitch_level;

  modport source (output valid, roll_level, pitch_level, input ready);
  modport sink (input valid, roll_level, pitch_level, output ready);
endinterface

interface tfl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tfl_pkg::CFG_IDX_W-1:0]    index;
  logic [tfl_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/tfl_level.sv
// error magnitude to led level: floor divide by 360, capped at 30
module tfl_level (
  input  logic [tfl_pkg::ERR_W-1:0]   err,
  output logic [tfl_pkg::LEVEL_W-1:0] level
);
  import tfl_pkg::*;

  logic [Y_W-1:0]     y;
  logic [RPROD_W-1:0] q;

  // below the cap err fits CAP_W bits; drop the factor of 8 first
  assign y = err[CAP_W-1:DIV_SHIFT];
  assign q = RPROD_W'(y) * RPROD_W'(RECIP);

  always_comb begin
    if (err >= ERR_W'(LEVEL_CAP)) begin
      level = LEVEL_W'(LEVEL_MAX);
    end else begin
      level = q[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT];
    end
  end

endmodule

>>> src/tilt_fir_led_level.sv
// Tilt to led level: each sample item (roll, pitch) is written into a shared history
// memory, then both channels run through one FIR whose taps live in a coefficient
// memory. A single 14x16 multiplier serves both channels, so a sample item runs a
// multiply-accumulate for each tap and channel, then read latency, drain, clamp, error
// and level steps. A coefficient item gives no result and leaves the block idle. The
// input is taken only between items; a finished result waits in the output register
// while the next item is accepted. Memory entries never written read as zero through
// per-entry valid bits, so no clearing pass is needed.
module tilt_fir_led_level #(
  parameter int TAPS = tfl_pkg::TAPS_DEF
) (
  input logic clk,
  input logic rst,
  tfl_in_if.sink    samples,
  tfl_out_if.source levels,
  tfl_cfg_if.sink   cfg
);
  import tfl_pkg::*;

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SW    = $clog2(2 * TAPS);
  localparam int ACC_W = PROD_W + $clog2(TAPS) + 2;
  localparam int HW    = 2 * ANGLE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ERR,
    ST_OUT
  } state_t;

  state_t state;

  // history holds {pitch, roll} per slot
  logic [HW-1:0]     hist_mem [TAPS];
  logic [COEF_W-1:0] coef_mem [TAPS];
  logic [TAPS-1:0]   hist_vld;
  logic [TAPS-1:0]   coef_vld;
  logic [HW-1:0]     hist_rd;
  logic              hist_rd_vld;
  logic [COEF_W-1:0] coef_rd;
  logic              coef_rd_vld;

  logic [AW-1:0] wslot;
  logic [AW-1:0] wslot_next;
  logic [AW-1:0] rp;
  logic [AW-1:0] ck;
  logic [SW-1:0] j;

  logic p1, p2, chan1, chan2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_roll, acc_pitch;
  logic [ERR_W-1:0]         mag_roll, mag_pitch;
  logic [ERR_W-1:0]         err_roll, err_pitch;
  logic [LEVEL_W-1:0]       lvl_roll, lvl_pitch;
  logic [GOAL_W-1:0]        roll_goal, pitch_goal;
  logic                     out_vld;
  logic [LEVEL_W-1:0]       out_roll, out_pitch;

  logic                      in_acc;
  logic [6:0]                cidx_ext;
  logic signed [ANGLE_W-1:0] smp;
  logic signed [COEF_W-1:0]  cf;

  function automatic logic [ERR_W-1:0] sat_mag(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] q;
    logic signed [ACC_W-1:0] s;
    q = a >>> FRAC_W;
    if (q > ACC_W'(FILT_MAX)) begin
      s = ACC_W'(FILT_MAX);
    end else if (q < ACC_W'(FILT_MIN)) begin
      s = ACC_W'(FILT_MIN);
    end else begin
      s = q;
    end
    if (s < 0) begin
      s = -s;
    end
    return s[ERR_W-1:0];
  endfunction

  function automatic logic [ERR_W-1:0] abs_err(input logic [ERR_W-1:0] m,
                                               input logic [GOAL_W-1:0] g);
    logic signed [ERR_W:0] d;
    d = signed'({1'b0, m}) - signed'((ERR_W + 1)'(g));
    if (d < 0) begin
      d = -d;
    end
    return d[ERR_W-1:0];
  endfunction

  assign in_acc     = samples.valid && samples.ready;
  assign cidx_ext   = 7'(samples.coef_index);
  assign wslot_next = (wslot == AW'(TAPS - 1)) ? '0 : wslot + 1'b1;

  assign samples.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign levels.valid       = out_vld;
  assign levels.roll_level  = out_roll;
  assign levels.pitch_level = out_pitch;

  // goal registers
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_goal  <= '0;
      pitch_goal <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_ROLL_GOAL:  roll_goal  <= cfg.data;
        REG_PITCH_GOAL: pitch_goal <= cfg.data;
      endcase
    end
  end

  // valid bits stand in for the all-zero reset of both memories
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      coef_vld <= '0;
    end else if (in_acc) begin
      if (samples.op == OP_SAMPLE) begin
        hist_vld[wslot] <= 1'b1;
      end else if (cidx_ext < 7'(TAPS)) begin
        coef_vld[cidx_ext[AW-1:0]] <= 1'b1;
      end
    end
  end

  // reads start the cycle after the write, so the new sample is always seen
  always_ff @(posedge clk) begin
    if (in_acc && samples.op == OP_SAMPLE) begin
      hist_mem[wslot] <= {samples.pitch_angle, samples.roll_angle};
    end
    hist_rd     <= hist_mem[rp];
    hist_rd_vld <= hist_vld[rp];
  end

  always_ff @(posedge clk) begin
    if (in_acc && samples.op == OP_COEF && cidx_ext < 7'(TAPS)) begin
      coef_mem[cidx_ext[AW-1:0]] <= samples.coef_value;
    end
    coef_rd     <= coef_mem[ck];
    coef_rd_vld <= coef_vld[ck];
  end

  assign smp = !hist_rd_vld ? '0 :
               chan1 ? signed'(hist_rd[HW-1:ANGLE_W]) : signed'(hist_rd[ANGLE_W-1:0]);
  assign cf  = coef_rd_vld ? signed'(coef_rd) : '0;

  tfl_level u_lvl_roll (
    .err   (err_roll),
    .level (lvl_roll)
  );

  tfl_level u_lvl_pitch (
    .err   (err_pitch),
    .level (lvl_pitch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wslot   <= '0;
      p1      <= 1'b0;
      p2      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      p1    <= (state == ST_RUN);
      p2    <= p1;
      chan1 <= j[0];
      chan2 <= chan1;
      if (p1) begin
        prod <= PROD_W'(smp) * PROD_W'(cf);
      end
      if (p2) begin
        if (chan2) begin
          acc_pitch <= acc_pitch + ACC_W'(prod);
        end else begin
          acc_roll <= acc_roll + ACC_W'(prod);
        end
      end
      // the output state reloads the register itself
      if (levels.ready && state != ST_OUT) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && samples.op == OP_SAMPLE) begin
            wslot     <= wslot_next;
            rp        <= wslot_next;
            ck        <= '0;
            j         <= '0;
            acc_roll  <= '0;
            acc_pitch <= '0;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          j <= j + 1'b1;
          // even step roll, odd step pitch, then on to the next tap
          if (j[0]) begin
            rp <= (rp == AW'(TAPS - 1)) ? '0 : rp + 1'b1;
            ck <= ck + 1'b1;
          end
          if (j == SW'(2 * TAPS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!p1 && !p2) begin
            mag_roll  <= sat_mag(acc_roll);
            mag_pitch <= sat_mag(acc_pitch);
            state     <= ST_ERR;
          end
        end
        ST_ERR: begin
          err_roll  <= abs_err(mag_roll, roll_goal);
          err_pitch <= abs_err(mag_pitch, pitch_goal);
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_vld || levels.ready) begin
            out_vld   <= 1'b1;
            out_roll  <= lvl_roll;
            out_pitch <= lvl_pitch;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (7'(ck) < 7'(TAPS)))
    else $error("coefficient address out of range");

  a_start_at_new_slot: assert property (@(posedge clk) disable iff (rst)
    (in_acc && samples.op == OP_SAMPLE) |=> (state == ST_RUN && j == '0 && rp == wslot))
    else $error("filter pass does not start at the oldest sample");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (levels.valid && levels.ready && state != ST_OUT) |=> !levels.valid)
    else $error("result shown twice");

  a_no_mac_outside_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_ERR || state == ST_OUT) |-> (!p1 && !p2))
    else $error("accumulation still in flight after the drain");

endmodule

>>> sim/tb_tilt_fir_led_level.sv
// testbench for tilt_fir_led_level: random items against a built-in fir and level predictor
`timescale 1ns / 1ps

module tb_tilt_fir_led_level;
  import tfl_pkg::*;

  localparam int TAPS        = TAPS_DEF;
  localparam int SETTLE      = 2 * TAPS + 10;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 180;
  localparam int LIMIT       = 1_000_000;

  typedef logic signed [ANGLE_W-1:0] angle_ring_t [TAPS];

  typedef struct {
    op_t                       op;
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
    logic [CIDX_W-1:0]         cidx;
    logic signed [COEF_W-1:0]  cval;
  } tilt_item_t;

  typedef struct {
    logic [LEVEL_W-1:0] roll;
    logic [LEVEL_W-1:0] pitch;
  } level_pair_t;

  logic clk = 1'b0;
  logic rst;

  tfl_in_if  samples_ch ();
  tfl_out_if levels_ch ();
  tfl_cfg_if cfg_ch ();

  tilt_fir_led_level #(.TAPS(TAPS)) uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .levels  (levels_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  angle_ring_t              roll_ring;
  angle_ring_t              pitch_ring;
  logic signed [COEF_W-1:0] coef_tab [TAPS];
  int                       ring_slot;
  int                       roll_goal;
  int                       pitch_goal;

  tilt_item_t  pending_items [$];
  level_pair_t expected_levels [$];

  int level_errors = 0;
  int cycle_count  = 0;
  int in_gap_max   = 0;
  int out_stall_max = 0;
  int in_wait      = 0;
  int out_wait     = 0;
  int hold_req     = 0;
  int hold_ack     = 0;
  int hold_left    = 0;
  logic in_fire    = 1'b0;
  logic out_fire   = 1'b0;

  // oldest sample meets coefficient 0, newest meets coefficient TAPS-1
  function automatic int filter_ring(input angle_ring_t ring);
    longint acc;
    int     idx;
    acc = 0;
    for (int k = 0; k < TAPS; k++) begin
      idx = ring_slot + k;
      if (idx >= TAPS) idx -= TAPS;
      acc += longint'(ring[idx]) * longint'(coef_tab[k]);
    end
    acc = acc >>> FRAC_W;
    if (acc > FILT_MAX) return FILT_MAX;
    if (acc < FILT_MIN) return FILT_MIN;
    return int'(acc);
  endfunction

  function automatic logic [LEVEL_W-1:0] led_level(input int filt, input int goal);
    int err;
    err = (filt < 0 ? -filt : filt) - goal;
    if (err < 0) err = -err;
    err = err / LEVEL_DIV;
    if (err > LEVEL_MAX) err = LEVEL_MAX;
    return err[LEVEL_W-1:0];
  endfunction

  task automatic predict_item(input tilt_item_t it);
    level_pair_t lv;
    if (it.op == OP_COEF) begin
      if (it.cidx < TAPS) coef_tab[it.cidx] = it.cval;
    end else begin
      roll_ring[ring_slot]  = it.roll;
      pitch_ring[ring_slot] = it.pitch;
      ring_slot = (ring_slot == TAPS - 1) ? 0 : ring_slot + 1;
      lv.roll  = led_level(filter_ring(roll_ring), roll_goal);
      lv.pitch = led_level(filter_ring(pitch_ring), pitch_goal);
      expected_levels.push_back(lv);
    end
  endtask

  // stimulus helpers, unused fields get random junk
  task automatic push_sample(input int r, input int p);
    tilt_item_t it;
    it.op    = OP_SAMPLE;
    it.roll  = ANGLE_W'(r);
    it.pitch = ANGLE_W'(p);
    it.cidx  = CIDX_W'($urandom_range(0, 31));
    it.cval  = COEF_W'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic push_coef(input int idx, input int v);
    tilt_item_t it;
    it.op    = OP_COEF;
    it.roll  = ANGLE_W'($urandom);
    it.pitch = ANGLE_W'($urandom);
    it.cidx  = CIDX_W'(idx);
    it.cval  = COEF_W'(v);
    pending_items.push_back(it);
  endtask

  function automatic int rand_angle();
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 16383)) - 8192;
      1: begin
        case ($urandom_range(0, 4))
          0: return -8192;
          1: return 8191;
          2: return -5760;
          3: return 5760;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(0, 11520)) - 5760;
    endcase
  endfunction

  function automatic int rand_goal();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 5760;
      2: return 8191;
      3: return int'($urandom_range(0, 8191));
      default: return int'($urandom_range(0, 5760));
    endcase
  endfunction

  task automatic load_coef_table(input int mode);
    int v;
    int tap;
    tap = $urandom_range(0, TAPS - 1);
    for (int k = 0; k < TAPS; k++) begin
      case (mode)
        0: v = int'($urandom_range(0, 65535)) - 32768;
        1: v = 1311 + int'($urandom_range(0, 200)) - 100;   // roughly a moving average
        2: v = (k == tap) ? (($urandom_range(0, 1) == 0) ? 32767 : -32768) : 0;
        default: v = int'($urandom_range(0, 6000)) - 3000;
      endcase
      push_coef(k, v);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(v);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || samples_ch.valid || expected_levels.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // sample side
  always @(negedge clk) begin
    tilt_item_t nxt;
    if (rst) begin
      samples_ch.valid <= 1'b0;
    end else if (samples_ch.valid && !in_fire) begin
      // hold the item until taken
    end else if (in_wait > 0) begin
      in_wait <= in_wait - 1;
      samples_ch.valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      nxt = pending_items.pop_front();
      samples_ch.op          <= nxt.op;
      samples_ch.roll_angle  <= nxt.roll;
      samples_ch.pitch_angle <= nxt.pitch;
      samples_ch.coef_index  <= nxt.cidx;
      samples_ch.coef_value  <= nxt.cval;
      samples_ch.valid       <= 1'b1;
      in_wait <= $urandom_range(0, in_gap_max);
    end else begin
      samples_ch.valid <= 1'b0;
    end
  end

  // long receiver hold-off
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // level side
  always @(negedge clk) begin
    int unsigned w;
    if (rst) begin
      levels_ch.ready <= 1'b0;
      out_wait <= 0;
    end else if (hold_left > 0) begin
      levels_ch.ready <= 1'b0;
    end else if (out_fire) begin
      w = $urandom_range(0, out_stall_max);
      out_wait <= w;
      levels_ch.ready <= (w == 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      levels_ch.ready <= (out_wait == 1);
    end else begin
      levels_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    tilt_item_t  seen;
    level_pair_t want;
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= samples_ch.valid && samples_ch.ready;
      out_fire <= levels_ch.valid && levels_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_ROLL_GOAL) roll_goal = int'(cfg_ch.data);
        else pitch_goal = int'(cfg_ch.data);
      end
      if (samples_ch.valid && samples_ch.ready) begin
        seen.op    = samples_ch.op;
        seen.roll  = samples_ch.roll_angle;
        seen.pitch = samples_ch.pitch_angle;
        seen.cidx  = samples_ch.coef_index;
        seen.cval  = samples_ch.coef_value;
        predict_item(seen);
      end
      if (levels_ch.valid && levels_ch.ready) begin
        if (expected_levels.size() == 0) begin
          level_errors++;
          if (level_errors <= 10)
            $display("unexpected level item roll %0d pitch %0d",
                     levels_ch.roll_level, levels_ch.pitch_level);
        end else begin
          want = expected_levels.pop_front();
          if (want.roll !== levels_ch.roll_level || want.pitch !== levels_ch.pitch_level) begin
            level_errors++;
            if (level_errors <= 10)
              $display("level mismatch: expected roll %0d pitch %0d, got roll %0d pitch %0d",
                       want.roll, want.pitch, levels_ch.roll_level, levels_ch.pitch_level);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("[tilt_fir_led_level] ERROR");
      $finish;
    end
  end

  initial begin
    int gap_sel [PHASES];
    int stall_sel [PHASES];
    int left;
    gap_sel   = '{17, 0, 17, 3, 0, 17, 17, 5};
    stall_sel = '{17, 0, 3, 17, 17, 0, 17, 5};
    rst = 1'b1;
    samples_ch.valid       = 1'b0;
    samples_ch.op          = OP_SAMPLE;
    samples_ch.roll_angle  = '0;
    samples_ch.pitch_angle = '0;
    samples_ch.coef_index  = '0;
    samples_ch.coef_value  = '0;
    levels_ch.ready        = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = REG_ROLL_GOAL;
    cfg_ch.data            = '0;
    for (int k = 0; k < TAPS; k++) begin
      roll_ring[k]  = '0;
      pitch_ring[k] = '0;
      coef_tab[k]   = '0;
    end
    ring_slot  = 0;
    roll_goal  = 0;
    pitch_goal = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, saturation both ways, ignored coefficient slots
    in_gap_max    = 3;
    out_stall_max = 3;
    write_reg(REG_ROLL_GOAL, 0);
    write_reg(REG_PITCH_GOAL, 8191);
    push_sample(5760, -5760);
    for (int k = 20; k < TAPS; k++) push_coef(k, 32767);
    push_coef(0, -32768);
    push_coef(31, 12345);
    push_coef(TAPS, -1);
    for (int k = 0; k < 6; k++) push_sample(8191, -8192);
    push_sample(-8192, 8191);
    push_sample(-5760, 5760);
    push_sample(0, 0);
    push_sample(1, -1);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      in_gap_max    = gap_sel[ph];
      out_stall_max = stall_sel[ph];
      case (ph)
        0: begin
          write_reg(REG_ROLL_GOAL, 0);
          write_reg(REG_PITCH_GOAL, 0);
        end
        1: begin
          write_reg(REG_ROLL_GOAL, 5760);
          write_reg(REG_PITCH_GOAL, 5760);
        end
        2: begin
          write_reg(REG_ROLL_GOAL, 8191);
          write_reg(REG_PITCH_GOAL, 0);
        end
        default: begin
          write_reg(REG_ROLL_GOAL, rand_goal());
          write_reg(REG_PITCH_GOAL, rand_goal());
        end
      endcase
      load_coef_table(ph % 4);
      left = PHASE_ITEMS;
      while (left > 0) begin
        if ($urandom_range(0, 19) == 0) begin
          push_coef(int'($urandom_range(0, 31)), int'($urandom_range(0, 65535)) - 32768);
        end else begin
          push_sample(rand_angle(), rand_angle());
          left--;
        end
      end
      // stall the level side while samples keep coming
      if (ph == 3) hold_req = hold_req + 1;
      wait_idle();
    end

    if (level_errors == 0) begin
      $display("[tilt_fir_led_level] OK");
    end else begin
      $display("[tilt_fir_led_level] ERROR");
    end
    $finish;
  end

endmodule

>>> tilt_fir_led_level.f
src/tfl_pkg.sv
src/tfl_ifs.sv
src/tfl_level.sv
src/tilt_fir_led_level.sv
sim/tb_tilt_fir_led_level.sv
